// ===== hw/rtl/gdrc_pkg.sv =====
`default_nettype none

package gdrc_pkg;

  // Operation codes of an input word.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_PLAYER_X      = 3'd0;
  localparam logic [2:0] REG_PLAYER_Y      = 3'd1;
  localparam logic [2:0] REG_DIR_X         = 3'd2;
  localparam logic [2:0] REG_DIR_Y         = 3'd3;
  localparam logic [2:0] REG_PLANE_X       = 3'd4;
  localparam logic [2:0] REG_PLANE_Y       = 3'd5;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd6;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd7;

  // Saturation value of the Q8.16 distances.
  localparam logic [23:0] SAT24 = 24'hFF_FFFF;

  typedef struct packed {
    logic       opcode;
    logic [9:0] column;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [7:0] cell_value;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  column_out;
    logic        hit_side;
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic [7:0]  hit_value;
    logic [23:0] wall_distance;
    logic [10:0] wall_start;
    logic [10:0] wall_end;
    logic        miss;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/grid_dda_column_raycaster.sv =====
`default_nettype none

// Channel   Signals                           Handshake
// cmd       start, busy, cmd                  taken when start is high and busy is low
// result    done, result                      one-cycle strobe, cannot be held off
// cfg       cfg_valid, cfg_ready, cfg_index,   written when cfg_valid and cfg_ready
//           cfg_data
//
// A map write leaves busy low. A cast runs three divisions on one shared 32-step
// restoring divider and four products, then walks the grid one cell at a time through
// S_STEP and S_CHECK (map read is registered); a hit with nonzero distance adds a
// fourth division for the slice height. After reset the map is cleared one cell a
// cycle with busy high; configuration writes are taken meanwhile. The result strobe
// is issued once and never stalls.

module grid_dda_column_raycaster #(
  parameter int MAP_SIZE  = 64,
  parameter int MAX_STEPS = 128
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  output logic                   busy,
  input  gdrc_pkg::cmd_t         cmd,
  output logic                   done,
  output gdrc_pkg::result_t      result,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [2:0]             cfg_index,
  input  wire  [15:0]            cfg_data
);
  import gdrc_pkg::*;

  localparam int DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int MW    = $clog2(DEPTH);
  localparam int CW    = (($clog2(MAP_SIZE) > 6) ? $clog2(MAP_SIZE) : 6) + 2;
  localparam int SDW   = 26 + $clog2(MAX_STEPS + 1);
  localparam int STW   = $clog2(MAX_STEPS + 1);

  typedef enum logic [15:0] {
    S_CLEAR     = 16'b0000000000000001,
    S_IDLE      = 16'b0000000000000010,
    S_CAM_DIV   = 16'b0000000000000100,
    S_MUL_X     = 16'b0000000000001000,
    S_MUL_Y     = 16'b0000000000010000,
    S_RAY_Y     = 16'b0000000000100000,
    S_DX_DIV    = 16'b0000000001000000,
    S_DY_LOAD   = 16'b0000000010000000,
    S_DY_DIV    = 16'b0000000100000000,
    S_SD_X      = 16'b0000001000000000,
    S_SD_Y      = 16'b0000010000000000,
    S_WALK_INIT = 16'b0000100000000000,
    S_STEP      = 16'b0001000000000000,
    S_CHECK     = 16'b0010000000000000,
    S_WH_DIV    = 16'b0100000000000000,
    S_FINISH    = 16'b1000000000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic        [15:0] player_x, player_y;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
  logic        [10:0] screen_width, screen_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x      <= 16'd1536;
      player_y      <= 16'd1536;
      dir_x         <= 16'sd16384;
      dir_y         <= 16'sd0;
      plane_x       <= 16'sd0;
      plane_y       <= 16'sd10813;
      screen_width  <= 11'd320;
      screen_height <= 11'd240;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PLAYER_X:      player_x      <= cfg_data;
        REG_PLAYER_Y:      player_y      <= cfg_data;
        REG_DIR_X:         dir_x         <= cfg_data;
        REG_DIR_Y:         dir_y         <= cfg_data;
        REG_PLANE_X:       plane_x       <= cfg_data;
        REG_PLANE_Y:       plane_y       <= cfg_data;
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[10:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Map memory: one write port, one registered read port.
  logic [7:0]    mem [DEPTH];
  logic [MW-1:0] clr_addr;
  logic          we;
  logic [MW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [MW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          item_write;

  assign item_write = (state == S_IDLE) && start && (cmd.opcode == OP_WRITE) &&
                      (int'(cmd.cell_x) < MAP_SIZE) && (int'(cmd.cell_y) < MAP_SIZE);

  always_comb begin
    if (state == S_CLEAR) begin
      we      = 1'b1;
      wr_addr = clr_addr;
      wr_data = 8'd0;
    end else begin
      we      = item_write;
      wr_addr = MW'(cmd.cell_x) * MW'(MAP_SIZE) + MW'(cmd.cell_y);
      wr_data = cmd.cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // Shared restoring divider, one quotient bit a cycle.
  logic [31:0] div_n, div_q;
  logic [27:0] div_d;
  logic [28:0] div_r, div_rsh;
  logic [4:0]  div_cnt;
  logic        div_ge, div_load, div_last;
  logic [31:0] div_load_n;
  logic [27:0] div_load_d;

  assign div_rsh  = {div_r[27:0], div_n[31]};
  assign div_ge   = div_rsh >= {1'b0, div_d};
  assign div_last = div_cnt == 5'd31;

  // Cast datapath registers.
  logic        [9:0]     col;
  logic signed [27:0]    cam, rx, ry;
  logic signed [44:0]    mul_p;
  logic signed [27:0]    mul_a;
  logic signed [16:0]    mul_b;
  logic        [23:0]    dx, dy, perp_dist;
  logic        [SDW-1:0] sdx, sdy;
  logic signed [CW-1:0]  mx, my;
  logic        [STW-1:0] steps;
  logic                  side, miss_f;
  logic        [7:0]     val;

  // Derived values.
  logic signed [27:0]    cam_w;
  logic        [27:0]    rx_abs, ry_abs;
  logic        [10:0]    fx, fy;
  logic        [23:0]    q_sat;
  logic                  go_x;
  logic        [SDW-1:0] sdx_n, sdy_n, dsub;
  logic signed [CW-1:0]  mx_n, my_n;
  logic                  oob;
  logic        [9:0]     half;
  logic        [30:0]    wh;

  assign cam_w  = $signed({2'b00, div_q[25:0]}) - 28'sd16384;
  assign rx_abs = rx[27] ? 28'(-rx) : 28'(rx);
  assign ry_abs = ry[27] ? 28'(-ry) : 28'(ry);
  assign fx     = rx[27] ? {1'b0, player_x[9:0]} : 11'd1024 - {1'b0, player_x[9:0]};
  assign fy     = ry[27] ? {1'b0, player_y[9:0]} : 11'd1024 - {1'b0, player_y[9:0]};
  assign q_sat  = (div_q > 32'(SAT24)) ? SAT24 : div_q[23:0];

  // One DDA step: advance the axis with the nearer boundary, ties go to y.
  assign go_x  = sdx < sdy;
  assign sdx_n = go_x ? sdx + SDW'(dx) : sdx;
  assign sdy_n = go_x ? sdy : sdy + SDW'(dy);
  assign mx_n  = !go_x ? mx : (rx[27] ? mx - CW'(1) : mx + CW'(1));
  assign my_n  = go_x ? my : (ry[27] ? my - CW'(1) : my + CW'(1));
  assign oob   = (unsigned'(mx_n) >= CW'(MAP_SIZE)) || (unsigned'(my_n) >= CW'(MAP_SIZE));
  assign rd_addr = MW'(mx_n) * MW'(MAP_SIZE) + MW'(my_n);

  assign dsub = side ? sdy - SDW'(dy) : sdx - SDW'(dx);
  assign half = screen_height[10:1];
  assign wh   = (perp_dist == 24'd0) ? 31'(half) : div_q[31:1];

  // Multiplier operand selection.
  always_comb begin
    if (state == S_MUL_X) begin
      mul_a = cam_w;
      mul_b = $signed({plane_x[15], plane_x});
    end else if (state == S_MUL_Y) begin
      mul_a = cam;
      mul_b = $signed({plane_y[15], plane_y});
    end else if (state == S_SD_X) begin
      mul_a = $signed({4'b0, dx});
      mul_b = $signed({6'b0, fx});
    end else begin
      mul_a = $signed({4'b0, q_sat});
      mul_b = $signed({6'b0, fy});
    end
  end

  // Divider operand selection for the states that start a division.
  always_comb begin
    div_load   = 1'b0;
    div_load_n = 32'h4000_0000;
    div_load_d = rx_abs;
    unique case (state)
      S_IDLE: begin
        div_load   = start && (cmd.opcode == OP_CAST);
        div_load_n = 32'({cmd.column, 15'd0});
        div_load_d = (screen_width == 11'd0) ? 28'd1 : 28'(screen_width);
      end
      S_RAY_Y: begin
        div_load = 1'b1;
      end
      S_DY_LOAD: begin
        div_load   = 1'b1;
        div_load_d = ry_abs;
      end
      S_CHECK: begin
        div_load   = 1'b1;
        div_load_n = 32'({screen_height, 16'd0});
        div_load_d = (dsub > SDW'(SAT24)) ? 28'(SAT24) : 28'(dsub);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      div_n   <= div_load_n;
      div_d   <= div_load_d;
      div_r   <= 29'd0;
      div_q   <= 32'd0;
      div_cnt <= 5'd0;
    end else begin
      div_n   <= {div_n[30:0], 1'b0};
      div_r   <= div_ge ? div_rsh - {1'b0, div_d} : div_rsh;
      div_q   <= {div_q[30:0], div_ge};
      div_cnt <= div_cnt + 5'd1;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + MW'(1);
          if (clr_addr == MW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start && (cmd.opcode == OP_CAST)) begin
            col   <= cmd.column;
            state <= S_CAM_DIV;
          end
        end
        S_CAM_DIV: begin
          if (div_last) state <= S_MUL_X;
        end
        S_MUL_X: begin
          cam   <= cam_w;
          mul_p <= mul_a * mul_b;
          state <= S_MUL_Y;
        end
        S_MUL_Y: begin
          rx    <= 28'(mul_p >>> 14) + 28'(dir_x);
          mul_p <= mul_a * mul_b;
          state <= S_RAY_Y;
        end
        S_RAY_Y: begin
          ry    <= 28'(mul_p >>> 14) + 28'(dir_y);
          state <= S_DX_DIV;
        end
        S_DX_DIV: begin
          if (div_last) state <= S_DY_LOAD;
        end
        S_DY_LOAD: begin
          dx    <= (rx == 28'sd0) ? SAT24 : q_sat;
          state <= S_DY_DIV;
        end
        S_DY_DIV: begin
          if (div_last) state <= S_SD_X;
        end
        S_SD_X: begin
          dy    <= (ry == 28'sd0) ? SAT24 : q_sat;
          mul_p <= mul_a * mul_b;
          state <= S_SD_Y;
        end
        S_SD_Y: begin
          sdx   <= SDW'(mul_p[44:10]);
          mul_p <= $signed({4'b0, dy}) * mul_b;
          state <= S_WALK_INIT;
        end
        S_WALK_INIT: begin
          sdy    <= SDW'(mul_p[44:10]);
          mx     <= CW'(player_x[15:10]);
          my     <= CW'(player_y[15:10]);
          steps  <= '0;
          side   <= 1'b0;
          miss_f <= 1'b1;
          if ((int'(player_x[15:10]) < MAP_SIZE) && (int'(player_y[15:10]) < MAP_SIZE)) begin
            state <= S_STEP;
          end else begin
            state <= S_FINISH;
          end
        end
        S_STEP: begin
          sdx   <= sdx_n;
          sdy   <= sdy_n;
          mx    <= mx_n;
          my    <= my_n;
          side  <= !go_x;
          steps <= steps + STW'(1);
          state <= oob ? S_FINISH : S_CHECK;
        end
        S_CHECK: begin
          if (rd_data != 8'd0) begin
            miss_f    <= 1'b0;
            val       <= rd_data;
            perp_dist <= (dsub > SDW'(SAT24)) ? SAT24 : dsub[23:0];
            state     <= (dsub == '0) ? S_FINISH : S_WH_DIV;
          end else if (steps == STW'(MAX_STEPS)) begin
            state <= S_FINISH;
          end else begin
            state <= S_STEP;
          end
        end
        S_WH_DIV: begin
          if (div_last) state <= S_FINISH;
        end
        S_FINISH: begin
          done              <= 1'b1;
          result.column_out <= col;
          result.miss       <= miss_f;
          if (miss_f) begin
            result.hit_side      <= 1'b0;
            result.hit_x         <= 6'd0;
            result.hit_y         <= 6'd0;
            result.hit_value     <= 8'd0;
            result.wall_distance <= SAT24;
            result.wall_start    <= 11'(half);
            result.wall_end      <= 11'(half);
          end else begin
            result.hit_side      <= side;
            result.hit_x         <= 6'(mx);
            result.hit_y         <= 6'(my);
            result.hit_value     <= val;
            result.wall_distance <= perp_dist;
            if (wh >= 31'(half)) begin
              result.wall_start <= 11'd0;
              result.wall_end   <= screen_height;
            end else begin
              result.wall_start <= 11'(half) - 11'(wh);
              result.wall_end   <= 11'(half) + 11'(wh);
            end
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = state != S_IDLE;

endmodule

`default_nettype wire
